/* rtl/cdm_pkg.sv */
// Shared types, constants and state codes for the color distance mask block.
`default_nettype none

package cdm_pkg;

  localparam int ChanW    = 8;
  localparam int TgtW     = 12;
  localparam int GoalW    = 16;
  localparam int FloorW   = 8;
  localparam int GainW    = 12;
  localparam int DiffW    = 13;
  localparam int SqW      = 26;
  localparam int RemW     = 14;
  localparam int DistW    = 13;
  localparam int StepW    = 4;
  localparam int ScW      = 21;
  localparam int Prod1W   = 25;
  localparam int Prod2W   = 50;
  localparam int RecipSh  = 28;
  localparam int QuotW    = Prod2W - RecipSh;
  localparam int SpreadW  = ScW + 1;
  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 16;
  localparam int QDepth   = 4;
  localparam int QPtrW    = $clog2(QDepth);
  localparam int QCntW    = QPtrW + 1;

  localparam logic [StepW-1:0]  RootLastStep = 4'd12;
  localparam logic [ScW-1:0]    ScaledMax    = 21'h1F_FFFF;
  // ceil(2^28 / 10); exact quotient for every dividend below 2^25
  localparam logic [Prod1W-1:0] RecipDiv10   = 25'd26843546;
  localparam logic [Prod1W-1:0] RoundTenth   = 25'd5;
  // 4080 * g / 10 is exactly 408 * g
  localparam logic [8:0]        RMinMul      = 9'd408;
  localparam logic [11:0]       RelMax       = 12'd4080;
  localparam logic [GainW-1:0]  GainFloor    = 12'd10;
  localparam logic [GainW-1:0]  GainReset    = 12'd100;
  localparam logic [ScW-1:0]    RunMinReset  = 21'd40800;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_TARGET_A    = 3'd0,
    CFG_TARGET_B    = 3'd1,
    CFG_SPREAD_GOAL = 3'd2,
    CFG_GAIN_LIMIT  = 3'd3,
    CFG_MASK_FLOOR  = 3'd4
  } cfg_addr_e;

  typedef enum logic [2:0] {
    F_IDLE,
    F_SQA,
    F_SQB,
    F_ROOT,
    F_PUSH
  } front_state_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_DIV,
    B_SCALE,
    B_ACC,
    B_GAIN,
    B_RMIN,
    B_EMIT
  } back_state_e;

  typedef struct packed {
    logic [ChanW-1:0] chan_a;
    logic [ChanW-1:0] chan_b;
    logic             last_of_frame;
  } pix_t;

  typedef struct packed {
    logic [7:0]       closeness;
    logic             mask_bit;
    logic             frame_done;
    logic [GainW-1:0] next_gain;
  } res_t;

  typedef struct packed {
    logic [CfgAddrW-1:0] addr;
    logic [CfgDataW-1:0] wdata;
  } cfg_wr_t;

  typedef struct packed {
    logic [TgtW-1:0]   target_a;
    logic [TgtW-1:0]   target_b;
    logic [GoalW-1:0]  spread_goal;
    logic [GainW-1:0]  gain_limit;
    logic [FloorW-1:0] mask_floor;
  } cfg_t;

  typedef struct packed {
    logic [DistW-1:0] mag;
    logic             last;
  } dist_word_t;

endpackage

`default_nettype wire

/* rtl/cdm_if.sv */
// Valid/ready channel interfaces for pixels, results and register writes.
`default_nettype none

interface cdm_pix_if import cdm_pkg::*;;
  logic valid;
  logic ready;
  pix_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface cdm_res_if import cdm_pkg::*;;
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface cdm_cfg_if import cdm_pkg::*;;
  logic    valid;
  logic    ready;
  cfg_wr_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/cdm_front.sv */
// Front end: takes a pixel, squares the chroma offsets, bit-serial rounded root.
`default_nettype none

module cdm_front import cdm_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  cdm_pix_if.sink    pix_i,
  input  cfg_t       cfg_i,
  input  wire        q_full_i,
  output logic       q_push_o,
  output dist_word_t q_word_o
);

  front_state_e            state_q, state_d;
  logic signed [DiffW-1:0] da_q, da_d, db_q, db_d;
  logic                    last_q, last_d;
  logic [SqW-1:0]          sq_q, sq_d;
  logic [RemW-1:0]         rem_q, rem_d;
  logic [DistW-1:0]        root_q, root_d;
  logic [StepW-1:0]        step_q, step_d;

  logic signed [DiffW-1:0] diff_a, diff_b;
  logic signed [SqW-1:0]   sq_prod;
  logic [RemW+1:0]         rem_sh, trial;

  assign diff_a = signed'({1'b0, cfg_i.target_a}) - signed'({1'b0, pix_i.data.chan_a, 4'b0});
  assign diff_b = signed'({1'b0, cfg_i.target_b}) - signed'({1'b0, pix_i.data.chan_b, 4'b0});
  assign sq_prod = (state_q == F_SQA) ? da_q * da_q : db_q * db_q;
  assign rem_sh  = {rem_q, sq_q[SqW-1 -: 2]};
  assign trial   = {1'b0, root_q, 2'b01};

  always_comb begin
    state_d     = state_q;
    da_d        = da_q;
    db_d        = db_q;
    last_d      = last_q;
    sq_d        = sq_q;
    rem_d       = rem_q;
    root_d      = root_q;
    step_d      = step_q;
    pix_i.ready = 1'b0;
    q_push_o    = 1'b0;
    q_word_o.mag  = root_q + ((rem_q > {1'b0, root_q}) ? DistW'(1) : DistW'(0));
    q_word_o.last = last_q;
    case (state_q)
      F_IDLE: begin
        pix_i.ready = 1'b1;
        if (pix_i.valid) begin
          da_d    = diff_a;
          db_d    = diff_b;
          last_d  = pix_i.data.last_of_frame;
          state_d = F_SQA;
        end
      end
      F_SQA: begin
        sq_d    = unsigned'(sq_prod);
        state_d = F_SQB;
      end
      F_SQB: begin
        sq_d    = sq_q + unsigned'(sq_prod);
        rem_d   = '0;
        root_d  = '0;
        step_d  = '0;
        state_d = F_ROOT;
      end
      F_ROOT: begin
        // one result bit per cycle; remainder stays below 2*root + 1
        if (rem_sh >= trial) begin
          rem_d  = RemW'(rem_sh - trial);
          root_d = {root_q[DistW-2:0], 1'b1};
        end else begin
          rem_d  = RemW'(rem_sh);
          root_d = {root_q[DistW-2:0], 1'b0};
        end
        sq_d   = {sq_q[SqW-3:0], 2'b00};
        step_d = step_q + StepW'(1);
        if (step_q == RootLastStep) begin
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_full_i) begin
          q_push_o = 1'b1;
          state_d  = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    da_q   <= da_d;
    db_q   <= db_d;
    last_q <= last_d;
    sq_q   <= sq_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    step_q <= step_d;
  end

endmodule

`default_nettype wire

/* rtl/cdm_fifo.sv */
// Short queue of distance words between the front and back ends.
`default_nettype none

module cdm_fifo import cdm_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        push_i,
  input  dist_word_t push_word_i,
  output logic       full_o,
  input  wire        pop_i,
  output logic       empty_o,
  output dist_word_t pop_word_o
);

  dist_word_t        mem_q [QDepth];
  logic [QPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]  cnt_q;

  assign full_o     = (cnt_q == QCntW'(QDepth));
  assign empty_o    = (cnt_q == '0);
  assign pop_word_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + QCntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - QCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_word_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/cdm_back.sv */
// Back end: gain scaling, frame min/max, closeness and end-of-frame gain step.
`default_nettype none

module cdm_back import cdm_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  cfg_t       cfg_i,
  input  wire        q_empty_i,
  input  dist_word_t q_word_i,
  output logic       q_pop_o,
  cdm_res_if.source  res_o
);

  back_state_e              state_q, state_d;
  logic                     last_q, last_d;
  logic [Prod1W-1:0]        prod1_q, prod1_d;
  logic [Prod2W-1:0]        prod2_q, prod2_d;
  logic [ScW-1:0]           scaled_q, scaled_d;
  logic [7:0]               close_q, close_d;
  logic [GainW-1:0]         gain_q, gain_d;
  logic [ScW-1:0]           prev_min_q, prev_min_d;
  logic [ScW-1:0]           run_min_q, run_min_d;
  logic [ScW-1:0]           run_max_q, run_max_d;
  logic                     out_valid_q, out_valid_d;
  res_t                     out_word_q, out_word_d;

  logic [QuotW-1:0]         quot;
  logic signed [SpreadW-1:0] rel, spread, goal;
  logic [11:0]              rel_c;
  logic [12:0]              rel_rnd;
  logic [GainW:0]           g_step;

  assign quot    = prod2_q[Prod2W-1:RecipSh];
  assign rel     = signed'({1'b0, scaled_q}) - signed'({1'b0, prev_min_q});
  assign spread  = signed'({1'b0, run_max_q}) - signed'({1'b0, run_min_q});
  assign goal    = signed'(SpreadW'({cfg_i.spread_goal, 4'b0}));
  assign rel_rnd = {1'b0, rel_c} + 13'd8;

  always_comb begin
    if (rel < 0) begin
      rel_c = '0;
    end else if (rel > signed'(SpreadW'(RelMax))) begin
      rel_c = RelMax;
    end else begin
      rel_c = rel[11:0];
    end
  end

  // gain step toward the spread goal, then limit, then floor
  always_comb begin
    g_step = {1'b0, gain_q};
    if (spread < goal) begin
      g_step = g_step + 13'd1;
    end else if (spread > goal && gain_q != '0) begin
      g_step = g_step - 13'd1;
    end
    if (g_step > {1'b0, cfg_i.gain_limit}) begin
      g_step = {1'b0, cfg_i.gain_limit};
    end
    if (g_step < {1'b0, GainFloor}) begin
      g_step = {1'b0, GainFloor};
    end
  end

  always_comb begin
    state_d     = state_q;
    last_d      = last_q;
    prod1_d     = prod1_q;
    prod2_d     = prod2_q;
    scaled_d    = scaled_q;
    close_d     = close_q;
    gain_d      = gain_q;
    prev_min_d  = prev_min_q;
    run_min_d   = run_min_q;
    run_max_d   = run_max_q;
    out_word_d  = out_word_q;
    out_valid_d = out_valid_q && !res_o.ready;
    q_pop_o     = 1'b0;
    case (state_q)
      B_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          prod1_d = Prod1W'(q_word_i.mag) * Prod1W'(gain_q);
          last_d  = q_word_i.last;
          state_d = B_DIV;
        end
      end
      B_DIV: begin
        prod2_d = Prod2W'(prod1_q + RoundTenth) * Prod2W'(RecipDiv10);
        state_d = B_SCALE;
      end
      B_SCALE: begin
        scaled_d = (quot > QuotW'(ScaledMax)) ? ScaledMax : quot[ScW-1:0];
        state_d  = B_ACC;
      end
      B_ACC: begin
        if (scaled_q < run_min_q) begin
          run_min_d = scaled_q;
        end
        if (scaled_q > run_max_q) begin
          run_max_d = scaled_q;
        end
        close_d = 8'd255 - rel_rnd[11:4];
        state_d = last_q ? B_GAIN : B_EMIT;
      end
      B_GAIN: begin
        gain_d     = g_step[GainW-1:0];
        prev_min_d = run_min_q;
        run_max_d  = '0;
        state_d    = B_RMIN;
      end
      B_RMIN: begin
        run_min_d = ScW'(RMinMul) * ScW'(gain_q);
        state_d   = B_EMIT;
      end
      B_EMIT: begin
        if (!out_valid_q || res_o.ready) begin
          out_word_d.closeness  = close_q;
          out_word_d.mask_bit   = (close_q >= cfg_i.mask_floor);
          out_word_d.frame_done = last_q;
          out_word_d.next_gain  = gain_q;
          out_valid_d           = 1'b1;
          state_d               = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  assign res_o.valid = out_valid_q;
  assign res_o.data  = out_word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      gain_q      <= GainReset;
      prev_min_q  <= '0;
      run_min_q   <= RunMinReset;
      run_max_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      gain_q      <= gain_d;
      prev_min_q  <= prev_min_d;
      run_min_q   <= run_min_d;
      run_max_q   <= run_max_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_q     <= last_d;
    prod1_q    <= prod1_d;
    prod2_q    <= prod2_d;
    scaled_q   <= scaled_d;
    close_q    <= close_d;
    out_word_q <= out_word_d;
  end

  a_gain_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gain_q >= GainFloor)
    else $error("gain fell below floor");

  a_frame_rollover: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_GAIN |=> run_max_q == '0 && prev_min_q == $past(run_min_q))
    else $error("frame rollover did not move minimum");

  a_min_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_RMIN |=> run_min_q == ScW'(RMinMul) * ScW'(gain_q))
    else $error("running minimum not reloaded from gain");

endmodule

`default_nettype wire

/* rtl/color_distance_mask_autogain.sv */
// Top level: register file, front end, distance queue and back end.
`default_nettype none

// Color distance mask with automatic gain. Each pixel word (Lab a and b,
// offset by 128) yields one result word: closeness = 255 minus the rounded,
// 0..255 clamped distance to the target chroma, scaled by the gain in tenths
// and taken relative to the previous frame's minimum; a mask bit at the
// floor; the frame-end flag; and the gain after this pixel. On the last
// pixel the gain moves one tenth toward the spread goal (limit, then floor of
// 1.0). The front end takes one pixel at a time (accept, square a, square b,
// bit-serial root, queue push once the queue has room); its root loop sets
// the sustained pixel rate unless the output holds. The back end takes one
// queued word at a time (gain multiply, divide by ten, clamp, accumulate, a
// gain step and minimum reload on a frame's last pixel, emit once the output
// register is free) behind a 4-deep queue, and the front keeps taking pixels
// while a result waits at the output until the queue fills. Register writes
// are taken every cycle and must only happen while the block is idle.
module color_distance_mask_autogain import cdm_pkg::*; (
  input  wire       clk_i,
  input  wire       rst_ni,
  cdm_pix_if.sink   pix_i,
  cdm_res_if.source res_o,
  cdm_cfg_if.sink   cfg_i
);

  cfg_t       cfg_q, cfg_d;
  logic       q_push, q_full, q_pop, q_empty;
  dist_word_t q_push_word, q_pop_word;

  // register file; unknown indexes are dropped
  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.data.addr)
        CFG_TARGET_A:    cfg_d.target_a    = cfg_i.data.wdata[TgtW-1:0];
        CFG_TARGET_B:    cfg_d.target_b    = cfg_i.data.wdata[TgtW-1:0];
        CFG_SPREAD_GOAL: cfg_d.spread_goal = cfg_i.data.wdata[GoalW-1:0];
        CFG_GAIN_LIMIT:  cfg_d.gain_limit  = cfg_i.data.wdata[GainW-1:0];
        CFG_MASK_FLOOR:  cfg_d.mask_floor  = cfg_i.data.wdata[FloorW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_a    <= 12'd3325;
      cfg_q.target_b    <= 12'd3150;
      cfg_q.spread_goal <= 16'd1000;
      cfg_q.gain_limit  <= 12'd2550;
      cfg_q.mask_floor  <= 8'd20;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // front: offsets, squares, rounded root into the queue
  cdm_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .pix_i    (pix_i),
    .cfg_i    (cfg_q),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_word_o (q_push_word)
  );

  cdm_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_word_i (q_push_word),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .pop_word_o  (q_pop_word)
  );

  // back: gain, frame statistics, output register
  cdm_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_empty_i (q_empty),
    .q_word_i  (q_pop_word),
    .q_pop_o   (q_pop),
    .res_o     (res_o)
  );

endmodule

`default_nettype wire
